// ----- hw/rtl/ilbp_rotation_min_histogram_assert.svh -----
// Assertion macros shared by the RTL files.
// ILBP_ASSERT checks a property at every clock edge outside reset.
// ILBP_ASSERT_NEXT checks that a condition holds in the cycle after a trigger.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef ILBP_ROTATION_MIN_HISTOGRAM_ASSERT_SVH
`define ILBP_ROTATION_MIN_HISTOGRAM_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ILBP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ilbp assertion failed");
`define ILBP_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("ilbp assertion failed one cycle after trigger");
`else
`define ILBP_ASSERT(label, prop)
`define ILBP_ASSERT_NEXT(label, trig, cons)
`endif

`endif

// ----- hw/rtl/ilbp_pkg.sv -----
package ilbp_pkg;

  localparam int PIX_W    = 8;
  localparam int BIN_W    = 9;
  localparam int CODE_W   = 9;
  localparam int BCNT_W   = 21;
  localparam int OP_W     = 2;
  localparam int CFG_W    = 11;
  localparam int WIN_N    = 9;
  localparam int SUM_W    = 12;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RST = 11'd1024;
  localparam int MIN_WIDTH = 3;
  localparam logic [1:0] ROW_FULL = 2'd2;
  localparam int COL_FIRST_FULL = 2;

  // Histogram: two bins per memory row, one valid flop per row.
  localparam int HIST_ROWS = 256;
  localparam int ROW_AW    = 8;

  // Output queue sizing; also the credit limit on words in flight.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = 3;
  localparam int OQ_CNT_W = 4;

  typedef enum logic [1:0] {
    HC_NONE  = 2'd0,
    HC_INC   = 2'd1,
    HC_READ  = 2'd2,
    HC_CLEAR = 2'd3
  } hist_cmd_t;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic [BIN_W-1:0] bin;
    logic            full;
  } pipe_t;

  typedef struct packed {
    logic             valid;
    hist_cmd_t        cmd;
    logic [BIN_W-1:0] bin;
  } hist_req_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [BCNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic                valid;
    logic                done;
    logic [OQ_CNT_W-1:0] level;
  } q_stat_t;

endpackage

// ----- hw/rtl/ilbp_linebuf.sv -----
module ilbp_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ilbp_pkg::PIX_W-1:0] wr_pix,
  output logic [ilbp_pkg::PIX_W-1:0] top_o,
  output logic [ilbp_pkg::PIX_W-1:0] mid_o
);

  localparam int PW = ilbp_pkg::PIX_W;

  // Word layout: {row two above, row above}.
  logic [2*PW-1:0] mem [DEPTH];
  logic [2*PW-1:0] rdata_r;

  // Write back: the row above moves up, the new pixel becomes the row above.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= {rdata_r[PW-1:0], wr_pix};
    end
  end

  assign top_o = rdata_r[2*PW-1:PW];
  assign mid_o = rdata_r[PW-1:0];

endmodule

// ----- hw/rtl/ilbp_code.sv -----
module ilbp_code (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ilbp_pkg::pipe_t            s1_i,
  input  logic [ilbp_pkg::PIX_W-1:0] top_i,
  input  logic [ilbp_pkg::PIX_W-1:0] mid_i,
  input  logic [ilbp_pkg::PIX_W-1:0] bot_i,
  output ilbp_pkg::hist_req_t        req_o
);

  localparam int PW = ilbp_pkg::PIX_W;
  localparam int SW = ilbp_pkg::SUM_W;
  localparam int N  = ilbp_pkg::WIN_N;
  localparam int CDW = ilbp_pkg::CODE_W;

  function automatic logic [CDW-1:0] rot_min9(input logic [CDW-1:0] c);
    logic [CDW-1:0] best;
    logic [CDW-1:0] v;
    best = c;
    v = c;
    for (int k = 1; k < CDW; k++) begin
      v = {v[CDW-2:0], v[CDW-1]};
      if (v < best) begin
        best = v;
      end
    end
    return best;
  endfunction

  logic [PW-1:0]  win_r  [N];
  logic [PW-1:0]  win3_r [N];
  logic [SW-1:0]  sum3_r;
  logic [CDW-1:0] code4_r;
  ilbp_pkg::pipe_t c2_r, c3_r, c4_r;

  logic           shift;
  logic [SW-1:0]  sum_nxt;
  logic [CDW-1:0] code_nxt;
  logic [CDW-1:0] rmin;

  assign shift = s1_i.valid && (s1_i.op == ilbp_pkg::OP_PUSH);

  // Shift the window left and insert the new column on every pushed pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_i;
      win_r[5] <= mid_i;
      win_r[8] <= bot_i;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < N; i++) begin
      sum_nxt = sum_nxt + SW'(win_r[i]);
    end
  end

  // Pixel above mean, exactly: 9*p > sum. Top-left lands in the MSB.
  always_comb begin
    logic [SW-1:0] p9;
    code_nxt = '0;
    for (int i = 0; i < N; i++) begin
      p9 = {win3_r[i], 3'b000} + SW'(win3_r[i]);
      code_nxt[N-1-i] = (p9 > sum3_r);
    end
  end

  always_ff @(posedge clk) begin
    sum3_r  <= sum_nxt;
    win3_r  <= win_r;
    code4_r <= code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
    end else begin
      c2_r <= s1_i;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  assign rmin = rot_min9(code4_r);

  always_comb begin
    req_o.valid = c4_r.valid;
    req_o.bin   = c4_r.bin;
    case (c4_r.op)
      ilbp_pkg::OP_PUSH: begin
        req_o.cmd = c4_r.full ? ilbp_pkg::HC_INC : ilbp_pkg::HC_NONE;
        req_o.bin = rmin;
      end
      ilbp_pkg::OP_READ:  req_o.cmd = ilbp_pkg::HC_READ;
      ilbp_pkg::OP_CLEAR: req_o.cmd = ilbp_pkg::HC_CLEAR;
      default:            req_o.cmd = ilbp_pkg::HC_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/ilbp_hist.sv -----
`include "ilbp_rotation_min_histogram_assert.svh"

module ilbp_hist #(
  parameter int COUNT_BITS = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ilbp_pkg::hist_req_t req_i,
  output logic                res_valid_o,
  output logic                done_o,
  output ilbp_pkg::res_t      res_o
);

  localparam int RW  = 2 * COUNT_BITS;
  localparam int BW  = ilbp_pkg::BIN_W;
  localparam int OW  = ilbp_pkg::BCNT_W;
  localparam int CX  = (COUNT_BITS > OW) ? COUNT_BITS : OW;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [RW-1:0] mem [ilbp_pkg::HIST_ROWS];
  logic [RW-1:0] rdata_r;
  ilbp_pkg::hist_req_t h1_r;
  logic [ilbp_pkg::HIST_ROWS-1:0] vld_r;
  logic                      fwd_v_r;
  logic [ilbp_pkg::ROW_AW-1:0] fwd_row_r;
  logic [RW-1:0]             fwd_data_r;

  logic [ilbp_pkg::ROW_AW-1:0] h1_row;
  logic                      is_inc, is_read, is_clear;
  logic                      fwd_hit;
  logic [RW-1:0]             base;
  logic [COUNT_BITS-1:0]     cnt, cnt_inc;
  logic [RW-1:0]             new_row;
  logic [CX-1:0]             cnt_ext;

  assign h1_row   = h1_r.bin[BW-1:1];
  assign is_inc   = h1_r.valid && (h1_r.cmd == ilbp_pkg::HC_INC);
  assign is_read  = h1_r.valid && (h1_r.cmd == ilbp_pkg::HC_READ);
  assign is_clear = h1_r.valid && (h1_r.cmd == ilbp_pkg::HC_CLEAR);

  // The row written last cycle was read before the write landed: forward it.
  assign fwd_hit = fwd_v_r && (fwd_row_r == h1_row);
  assign base    = fwd_hit ? fwd_data_r : (vld_r[h1_row] ? rdata_r : '0);
  assign cnt     = h1_r.bin[0] ? base[RW-1:COUNT_BITS] : base[COUNT_BITS-1:0];
  assign cnt_inc = (cnt == CMAX) ? cnt : cnt + COUNT_BITS'(1);
  assign new_row = h1_r.bin[0] ? {cnt_inc, base[COUNT_BITS-1:0]}
                               : {base[RW-1:COUNT_BITS], cnt_inc};
  assign cnt_ext = CX'(cnt);

  always_ff @(posedge clk) begin
    if (req_i.valid) begin
      rdata_r <= mem[req_i.bin[BW-1:1]];
    end
    if (is_inc) begin
      mem[h1_row] <= new_row;
    end
    fwd_row_r  <= h1_row;
    fwd_data_r <= new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r.valid <= 1'b0;
      vld_r      <= '0;
      fwd_v_r    <= 1'b0;
    end else begin
      h1_r    <= req_i;
      fwd_v_r <= is_inc;
      if (is_clear) begin
        vld_r <= '0;
      end else if (is_inc) begin
        vld_r[h1_row] <= 1'b1;
      end
    end
  end

  assign res_valid_o = is_inc || is_read;
  assign done_o      = h1_r.valid && !(is_inc || is_read);
  assign res_o.kind  = is_read;
  assign res_o.code  = is_inc ? h1_r.bin : '0;
  assign res_o.count = is_read ? cnt_ext[OW-1:0] : '0;

  `ILBP_ASSERT_NEXT(a_inc_marks_row, is_inc, vld_r[$past(h1_row)])
  `ILBP_ASSERT_NEXT(a_clear_empties, is_clear, (vld_r == '0) && !fwd_v_r)

endmodule

// ----- hw/rtl/ilbp_outq.sv -----
module ilbp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  ilbp_pkg::res_t      data_i,
  input  logic                ready_i,
  output ilbp_pkg::res_t      data_o,
  output ilbp_pkg::q_stat_t   stat_o
);

  localparam int PTRW = ilbp_pkg::OQ_PTR_W;
  localparam int CNTW = ilbp_pkg::OQ_CNT_W;

  ilbp_pkg::res_t q_r [ilbp_pkg::OQ_DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            pop;

  assign stat_o.valid = (cnt_r != '0);
  assign stat_o.level = cnt_r;
  assign pop          = stat_o.valid && ready_i;
  assign stat_o.done  = pop;
  assign data_o       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + PTRW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTRW'(1);
      end
      cnt_r <= cnt_r + CNTW'(push_i) - CNTW'(pop);
    end
  end

endmodule

// ----- hw/rtl/ilbp_rotation_min_histogram.sv -----
// Rotation-invariant local binary pattern coder with a code histogram.
// in_* : one word per operation. in_tuser carries the op (push pixel, read
//   bin, start frame); in_tdata carries pixel and bin index.
// out_*: one word per result. out_tuser says whether out_tdata holds a
//   pattern code or a bin count. Pushes without a full 3x3 window, start
//   frame and the unused op give no output word.
// cfg_*: image width; the user writes it only while the block is idle, and the
//   block itself does not enforce this; always ready.
// Throughput: one input word per cycle, sustained with out_tready high.
// Pipeline: line buffer read, window, sum, compare, rotation minimum with
//   the histogram read, then the histogram update into the output queue.
//   Back-to-back increments of one bin are forwarded.
// Stall: results queue in an 8-entry output FIFO; in_tready drops while
//   8 accepted words are in flight or waiting, and nothing is lost.
// Reset: clears position, window, histogram row valid bits and the queue;
//   no clearing pass. Line buffer contents are undefined until the first
//   rows are written. Start frame restarts the raster position and clears the
//   histogram in order with the words around it; line buffers and window are kept.
`include "ilbp_rotation_min_histogram_assert.svh"

module ilbp_rotation_min_histogram #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COUNT_BITS = 21
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ilbp_pkg::IN_TDATA_W-1:0]      in_tdata,   // pixel[7:0], bin_index[16:8]
  input  logic [ilbp_pkg::OP_W-1:0]            in_tuser,   // op[1:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ilbp_pkg::OUT_TDATA_W-1:0]     out_tdata,  // pattern_code[8:0], bin_count[29:9]
  output logic                                 out_tuser,  // kind[0]
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ilbp_pkg::CFG_W-1:0]           cfg_data    // image_width[10:0]
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > ilbp_pkg::CFG_W) ? WW : ilbp_pkg::CFG_W;
  localparam int PW   = ilbp_pkg::PIX_W;
  localparam int BW   = ilbp_pkg::BIN_W;
  localparam int OCW  = ilbp_pkg::OQ_CNT_W;

  logic [ilbp_pkg::CFG_W-1:0] img_w_r;
  logic [CW-1:0]  col_r, col_nxt;
  logic [1:0]     row_r, row_nxt;
  logic [OCW-1:0] outst_r;

  logic [CMPW-1:0] wext, eff_w, col_inc;
  logic            wrap, full, accept, is_push, is_clear;
  logic [ilbp_pkg::OP_W-1:0] in_op;
  logic [PW-1:0]   in_pix;
  logic [BW-1:0]   in_bin;

  ilbp_pkg::pipe_t     s1_r;
  logic [CW-1:0]       s1_addr_r;
  logic [PW-1:0]       s1_pix_r;
  logic                lb_rd_en, lb_wr_en;
  logic [PW-1:0]       lb_top, lb_mid;
  ilbp_pkg::hist_req_t hreq;
  ilbp_pkg::res_t      hres, qdata;
  logic                hres_valid, hdone;
  ilbp_pkg::q_stat_t   oq_st;

  assign in_op  = in_tuser;
  assign in_pix = in_tdata[PW-1:0];
  assign in_bin = in_tdata[PW+BW-1:PW];

  // Hold a credit for every word between acceptance and its exit.
  assign in_tready = (outst_r < OCW'(ilbp_pkg::OQ_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign is_push   = accept && (in_op == ilbp_pkg::OP_PUSH);
  assign is_clear  = accept && (in_op == ilbp_pkg::OP_CLEAR);
  assign cfg_ready = 1'b1;

  // Clamp the configured width to the supported range.
  assign wext = CMPW'(img_w_r);
  always_comb begin
    if (wext < CMPW'(ilbp_pkg::MIN_WIDTH)) begin
      eff_w = CMPW'(ilbp_pkg::MIN_WIDTH);
    end else if (wext > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = wext;
    end
  end

  // Wrap the column at the row end; the row count saturates once two full
  // rows sit in the line buffers.
  assign col_inc = CMPW'(col_r) + CMPW'(1);
  assign wrap    = (col_inc >= eff_w);
  assign full    = (row_r == ilbp_pkg::ROW_FULL) && (col_r >= CW'(ilbp_pkg::COL_FIRST_FULL));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (is_clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (is_push) begin
      if (wrap) begin
        col_nxt = '0;
        if (row_r != ilbp_pkg::ROW_FULL) begin
          row_nxt = row_r + 2'd1;
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= ilbp_pkg::WIDTH_RST;
      col_r      <= '0;
      row_r      <= '0;
      outst_r    <= '0;
      s1_r.valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        img_w_r <= cfg_data;
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      outst_r <= outst_r + OCW'(accept) - OCW'(hdone) - OCW'(oq_st.done);
      s1_r.valid <= accept;
      s1_r.op    <= in_op;
      s1_r.bin   <= in_bin;
      s1_r.full  <= full;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= col_r;
    s1_pix_r  <= in_pix;
  end

  // Read the column on acceptance, write it back in the next cycle.
  assign lb_rd_en = is_push;
  assign lb_wr_en = s1_r.valid && (s1_r.op == ilbp_pkg::OP_PUSH);

  ilbp_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (lb_rd_en),
    .rd_addr (col_r),
    .wr_en   (lb_wr_en),
    .wr_addr (s1_addr_r),
    .wr_pix  (s1_pix_r),
    .top_o   (lb_top),
    .mid_o   (lb_mid)
  );

  ilbp_code u_code (
    .clk   (clk),
    .rst_n (rst_n),
    .s1_i  (s1_r),
    .top_i (lb_top),
    .mid_i (lb_mid),
    .bot_i (s1_pix_r),
    .req_o (hreq)
  );

  ilbp_hist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_i       (hreq),
    .res_valid_o (hres_valid),
    .done_o      (hdone),
    .res_o       (hres)
  );

  ilbp_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (hres_valid),
    .data_i  (hres),
    .ready_i (out_tready),
    .data_o  (qdata),
    .stat_o  (oq_st)
  );

  assign out_tvalid = oq_st.valid;
  assign out_tuser  = qdata.kind;
  assign out_tdata  = ilbp_pkg::OUT_TDATA_W'({qdata.count, qdata.code});

  // A column is never read in the cycle its previous pixel writes it back.
  `ILBP_ASSERT(a_lb_no_overlap, !(lb_rd_en && lb_wr_en && (col_r == s1_addr_r)))
  // Queued results are always covered by credits.
  `ILBP_ASSERT(a_credit_covers_queue, oq_st.level <= outst_r)

endmodule

// ----- tb/tb_ilbp_rotation_min_histogram.sv -----
module tb_ilbp_rotation_min_histogram;

  // Op code that the block ignores.
  localparam logic [ilbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned LINE_MAX    = 1024;
  localparam int unsigned BIN_MAX     = (1 << ilbp_pkg::BCNT_W) - 1;
  localparam int          STALL_LIMIT = 2000;
  // Pipeline depth plus margin; wait this long before touching the width.
  localparam int          SETTLE      = 12;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [ilbp_pkg::IN_TDATA_W-1:0]  in_tdata;   // pixel[7:0], bin_index[16:8]
  logic [ilbp_pkg::OP_W-1:0]        in_tuser;   // op[1:0]
  logic                             out_tvalid;
  logic                             out_tready;
  logic [ilbp_pkg::OUT_TDATA_W-1:0] out_tdata;  // pattern_code[8:0], bin_count[29:9]
  logic                             out_tuser;  // kind[0]
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [ilbp_pkg::CFG_W-1:0]       cfg_data;   // image_width[10:0]

  ilbp_rotation_min_histogram u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the block: line buffers, window, raster position,
  // histogram and the width register.
  // ---------------------------------------------------------------------
  logic [ilbp_pkg::PIX_W-1:0]  lb_above     [LINE_MAX];
  logic [ilbp_pkg::PIX_W-1:0]  lb_two_above [LINE_MAX];
  logic [ilbp_pkg::PIX_W-1:0]  win          [ilbp_pkg::WIN_N];
  logic [ilbp_pkg::BCNT_W-1:0] hist         [512];
  int unsigned                 col_pos;
  int unsigned                 row_pos;
  logic [ilbp_pkg::CFG_W-1:0]  width_reg;
  logic [ilbp_pkg::CODE_W-1:0] last_code;
  // Writes seen per line buffer column, saturating at two; a column is only
  // safe to feed into a full window once it has been pushed twice.
  int unsigned                 col_fill     [LINE_MAX];

  // Words the block still owes, oldest first.
  ilbp_pkg::res_t              code_count_q [$];

  int                          mismatch_cnt;
  bit                          no_gaps;

  typedef struct {
    logic [ilbp_pkg::OP_W-1:0]  op;
    logic [ilbp_pkg::PIX_W-1:0] pix;
    logic [ilbp_pkg::BIN_W-1:0] bin;
    bit                         typed;    // use the value below instead of the shadow model
    bit                         has_res;
    ilbp_pkg::res_t             want;
  } dir_row_t;

  localparam ilbp_pkg::res_t R_NONE  = '0;
  localparam ilbp_pkg::res_t R_CNT0  = '{1'b1, 9'd0, 21'd0};
  localparam ilbp_pkg::res_t R_CNT1  = '{1'b1, 9'd0, 21'd1};
  localparam ilbp_pkg::res_t R_CODE0 = '{1'b0, 9'd0, 21'd0};

  // Directed words, run with the width at three pixels.
  dir_row_t dir_tab [23] = '{
    // reads right after reset see an empty histogram; the unused op is dropped
    '{ilbp_pkg::OP_READ,  8'hff, 9'h000, 1'b1, 1'b1, R_CNT0},
    '{ilbp_pkg::OP_READ,  8'h00, 9'h1ff, 1'b1, 1'b1, R_CNT0},
    '{OP_UNUSED,          8'hff, 9'h1ff, 1'b1, 1'b0, R_NONE},
    // three rows of white: no word until the window is full, then code zero
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h000, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h1ff, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h000, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h1ff, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h000, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h1ff, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h000, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h1ff, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h000, 1'b1, 1'b1, R_CODE0},
    '{ilbp_pkg::OP_READ,  8'h00, 9'h000, 1'b1, 1'b1, R_CNT1},
    // black row under white, then a mixed row
    '{ilbp_pkg::OP_PUSH,  8'h00, 9'h1ff, 1'b0, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'h00, 9'h0aa, 1'b0, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'h00, 9'h155, 1'b0, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'hff, 9'h0aa, 1'b0, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'h00, 9'h155, 1'b0, 1'b0, R_NONE},
    '{ilbp_pkg::OP_PUSH,  8'h80, 9'h000, 1'b0, 1'b0, R_NONE},
    // start frame wipes the histogram and restarts the raster
    '{ilbp_pkg::OP_CLEAR, 8'hff, 9'h1ff, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_READ,  8'h55, 9'h000, 1'b1, 1'b1, R_CNT0},
    '{ilbp_pkg::OP_PUSH,  8'h7f, 9'h155, 1'b1, 1'b0, R_NONE},
    '{ilbp_pkg::OP_READ,  8'haa, 9'h03f, 1'b1, 1'b1, R_CNT0}
  };

  // Width settings, extremes and out-of-range values among them.
  int unsigned phase_width [12] = '{0, 5, 17, 2, 9, 64, 4, 2047, 11, 3, 33, 1};

  function automatic int unsigned eff_width(input logic [ilbp_pkg::CFG_W-1:0] w);
    if (w < ilbp_pkg::MIN_WIDTH) return ilbp_pkg::MIN_WIDTH;
    if (w > LINE_MAX) return LINE_MAX;
    return w;
  endfunction

  function automatic logic [ilbp_pkg::CODE_W-1:0] rot_min(
      input logic [ilbp_pkg::CODE_W-1:0] c);
    logic [ilbp_pkg::CODE_W-1:0] best;
    logic [ilbp_pkg::CODE_W-1:0] v;
    best = c;
    v    = c;
    for (int k = 1; k < ilbp_pkg::CODE_W; k++) begin
      v = {v[ilbp_pkg::CODE_W-2:0], v[ilbp_pkg::CODE_W-1]};
      if (v < best) best = v;
    end
    return best;
  endfunction

  // Advance the shadow state by one word; return 1 when a word is owed.
  function automatic bit run_lbp_histogram(input logic [ilbp_pkg::OP_W-1:0] op,
                                           input logic [ilbp_pkg::PIX_W-1:0] pix,
                                           input logic [ilbp_pkg::BIN_W-1:0] bin,
                                           output ilbp_pkg::res_t r);
    int unsigned                 c;
    int unsigned                 w;
    int unsigned                 sum;
    logic [ilbp_pkg::CODE_W-1:0] code;
    bit                          full;
    r = '0;
    case (op)
      ilbp_pkg::OP_READ: begin
        r.kind  = 1'b1;
        r.count = hist[bin];
        return 1'b1;
      end
      ilbp_pkg::OP_CLEAR: begin
        foreach (hist[k]) hist[k] = '0;
        col_pos = 0;
        row_pos = 0;
        return 1'b0;
      end
      ilbp_pkg::OP_PUSH: begin
        w = eff_width(width_reg);
        c = col_pos;
        if (c >= LINE_MAX) c = 0;
        // shift the window left, bring in the new column top to bottom
        for (int rr = 0; rr < 3; rr++) begin
          win[rr*3]   = win[rr*3+1];
          win[rr*3+1] = win[rr*3+2];
        end
        win[2] = lb_two_above[c];
        win[5] = lb_above[c];
        win[8] = pix;
        lb_two_above[c] = lb_above[c];
        lb_above[c]     = pix;
        if (col_fill[c] < 2) col_fill[c]++;
        full = (row_pos >= 2) && (c >= ilbp_pkg::COL_FIRST_FULL);
        if (c + 1 >= w) begin
          col_pos = 0;
          if (row_pos < 2) row_pos++;
        end else begin
          col_pos = c + 1;
        end
        if (!full) return 1'b0;
        sum = 0;
        for (int k = 0; k < ilbp_pkg::WIN_N; k++) sum += win[k];
        code = '0;
        // row-major, top-left pixel lands in the MSB
        for (int k = 0; k < ilbp_pkg::WIN_N; k++)
          code = {code[ilbp_pkg::CODE_W-2:0], (9 * win[k] > sum)};
        code = rot_min(code);
        if (hist[code] < BIN_MAX) hist[code]++;
        r.code    = code;
        last_code = code;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // True when every column the next pushes can read has been written twice.
  function automatic bit lines_filled(input int unsigned w);
    int unsigned span;
    span = (w > col_pos + 1) ? w : col_pos + 1;
    for (int k = 0; k < span; k++) if (col_fill[k] < 2) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < 200)
      $display("mismatch: %s got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // Offer one word, with random gaps ahead of it unless no_gaps is set; return once it is taken.
  task automatic issue_word(input logic [ilbp_pkg::OP_W-1:0] op,
                            input logic [ilbp_pkg::PIX_W-1:0] pix,
                            input logic [ilbp_pkg::BIN_W-1:0] bin, input bit typed,
                            input bit has_res, input ilbp_pkg::res_t want);
    ilbp_pkg::res_t r;
    bit             owed;
    if (!no_gaps) begin
      while ($urandom_range(99) < 35) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, bin, pix};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    owed = run_lbp_histogram(op, pix, bin, r);
    if (typed) begin
      if (has_res) code_count_q.push_back(want);
    end else if (owed) begin
      code_count_q.push_back(r);
    end
  endtask

  // Drain, let the pipeline settle, then write the width register.
  task automatic write_width(input logic [ilbp_pkg::CFG_W-1:0] w);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (code_count_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  // Check every result word against the oldest one owed; toggle out_tready.
  always @(posedge clk) begin : out_check
    ilbp_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (code_count_q.size() == 0) begin
        report_mismatch("word with none owed", out_tdata, 32'd0);
      end else begin
        want = code_count_q.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[8:0] !== want.code)
          report_mismatch("pattern_code", out_tdata[8:0], want.code);
        if (out_tdata[29:9] !== want.count)
          report_mismatch("bin_count", out_tdata[29:9], want.count);
      end
    end
    out_tready <= no_gaps || ($urandom_range(99) >= 35);
  end

  // Stop the run when no handshake of any kind completes for too long.
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        stall = 0;
      else
        stall++;
    end
    $display("tb_ilbp_rotation_min_histogram: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned                 w_eff;
    int                          len;
    int                          sel;
    bit                          keep;
    logic [ilbp_pkg::OP_W-1:0]   op;
    logic [ilbp_pkg::PIX_W-1:0]  pix;
    logic [ilbp_pkg::BIN_W-1:0]  bin;

    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ilbp_pkg::OP_PUSH;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    mismatch_cnt = 0;
    no_gaps      = 1'b0;

    // shadow state after reset
    foreach (lb_above[k]) begin
      lb_above[k]     = '0;
      lb_two_above[k] = '0;
      col_fill[k]     = 0;
    end
    foreach (win[k]) win[k] = '0;
    foreach (hist[k]) hist[k] = '0;
    col_pos   = 0;
    row_pos   = 0;
    width_reg = ilbp_pkg::WIDTH_RST;
    last_code = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_width(11'd3);
    foreach (dir_tab[k])
      issue_word(dir_tab[k].op, dir_tab[k].pix, dir_tab[k].bin, dir_tab[k].typed,
                 dir_tab[k].has_res, dir_tab[k].want);

    // Random phases: mostly pixel runs long enough to fill the window, with
    // reads, start frames and the unused op mixed in as noise.
    for (int p = 0; p < 12; p++) begin
      w_eff = eff_width(ilbp_pkg::CFG_W'(phase_width[p]));
      write_width(ilbp_pkg::CFG_W'(phase_width[p]));
      // now and then keep the raster going so the width changes mid-row
      keep = (p % 3 == 2) && lines_filled(w_eff);
      if (!keep) begin
        pix = ilbp_pkg::PIX_W'($urandom_range(255));
        bin = ilbp_pkg::BIN_W'($urandom_range(511));
        issue_word(ilbp_pkg::OP_CLEAR, pix, bin, 1'b0, 1'b0, R_NONE);
      end
      no_gaps = (p == 5);
      // the widest rows only get a short run of pushes and reads
      len = (w_eff > 64) ? 100 : 3 * w_eff + 50;
      for (int i = 0; i < len; i++) begin
        // hold off once in a while until every owed word has come out
        if (p % 4 == 1 && i == len / 2) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (code_count_q.size() != 0) @(posedge clk);
        end
        sel = $urandom_range(99);
        if (w_eff > 64)
          op = (sel < 98) ? ilbp_pkg::OP_PUSH : ilbp_pkg::OP_READ;
        else if (sel < 84)
          op = ilbp_pkg::OP_PUSH;
        else if (sel < 95)
          op = ilbp_pkg::OP_READ;
        else if (sel < 98)
          op = ilbp_pkg::OP_CLEAR;
        else
          op = OP_UNUSED;
        case ($urandom_range(3))
          0: pix = $urandom_range(1) ? 8'hff : 8'h00;
          1: pix = ilbp_pkg::PIX_W'($urandom_range(3) * 85);
          default: pix = ilbp_pkg::PIX_W'($urandom_range(255));
        endcase
        bin = $urandom_range(1) ? last_code : ilbp_pkg::BIN_W'($urandom_range(511));
        issue_word(op, pix, bin, 1'b0, 1'b0, R_NONE);
      end
      no_gaps = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (code_count_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb_ilbp_rotation_min_histogram: PASS");
    else
      $display("tb_ilbp_rotation_min_histogram: FAIL");
    $finish;
  end

endmodule
